// ----- rtl/core/ecb_pkg.sv -----
// Shared constants, codes and types of the clipped-border box/cross blur.
// No dependencies; compile first.
package ecb_pkg;

  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned MAX_RADIUS     = 7;
  localparam int unsigned RING_ROWS      = 2 * MAX_RADIUS + 2;
  localparam int unsigned COL_W          = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W         = $clog2(RING_ROWS);
  localparam int unsigned ADDR_W         = SLOT_W + COL_W;
  localparam int unsigned ROW_W          = 16;
  localparam int unsigned WID_W          = 11;
  localparam int unsigned RAD_W          = 3;
  localparam int unsigned STEP_W         = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned PIX_W          = 3 * CHAN_W;
  localparam int unsigned SUM_W          = 16;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned JOB_FIFO_DEPTH = 2;
  localparam int unsigned JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);

  localparam logic SHAPE_SQUARE = 1'b0;
  localparam logic SHAPE_CROSS  = 1'b1;
  localparam logic FUNC_PIXEL   = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_WINDOW_RADIUS = 3'd2,
    CFG_WINDOW_SHAPE  = 3'd3,
    CFG_COLOR_MODE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [RAD_W-1:0] radius;
    logic             shape;
    logic             color;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } back_stat_t;

endpackage

// ----- rtl/core/ecb_in_if.sv -----
// Pixel input channel: valid/ready handshake with function code and three channels.
// Depends on ecb_pkg.
interface ecb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ecb_pkg::CHAN_W-1:0] in_chan0;
  logic [ecb_pkg::CHAN_W-1:0] in_chan1;
  logic [ecb_pkg::CHAN_W-1:0] in_chan2;
  modport source (output valid, func, in_chan0, in_chan1, in_chan2, input ready);
  modport sink   (input valid, func, in_chan0, in_chan1, in_chan2, output ready);
endinterface

// ----- rtl/core/ecb_out_if.sv -----
// Blurred pixel output channel: valid/ready handshake with means, count and frame end.
// Depends on ecb_pkg.
interface ecb_out_if;
  logic                       valid;
  logic                       ready;
  logic [ecb_pkg::CHAN_W-1:0] out_chan0;
  logic [ecb_pkg::CHAN_W-1:0] out_chan1;
  logic [ecb_pkg::CHAN_W-1:0] out_chan2;
  logic [ecb_pkg::CNT_W-1:0]  window_count;
  logic                       frame_last;
  modport source (output valid, out_chan0, out_chan1, out_chan2, window_count, frame_last,
                  input ready);
  modport sink   (input valid, out_chan0, out_chan1, out_chan2, window_count, frame_last,
                  output ready);
endinterface

// ----- rtl/core/ecb_cfg_if.sv -----
// Register write channel: valid/ready handshake with register index and write data.
// Depends on ecb_pkg.
interface ecb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ecb_pkg::CFG_IDX_W-1:0]  index;
  logic [ecb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ecb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ecb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ecb_job_fifo.sv -----
// Short queue of output positions between the front and the back.
// Depends on ecb_pkg.
module ecb_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ecb_pkg::job_t job_i,
  input  logic          pop_i,
  output ecb_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  ecb_pkg::job_t                   mem_q [ecb_pkg::JOB_FIFO_DEPTH];
  logic [ecb_pkg::JOB_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ecb_pkg::JOB_PTR_W:0]     count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (ecb_pkg::JOB_PTR_W+1)'(ecb_pkg::JOB_FIFO_DEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/ecb_front.sv -----
// Front: accepts pixels and flush ticks, writes the line store, issues ready positions.
// Depends on ecb_pkg and ecb_in_if.
module ecb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ecb_in_if.sink                      pix_in,
  input  ecb_pkg::cfg_t               cfg_i,
  input  logic                        fifo_empty_i,
  input  ecb_pkg::back_stat_t         back_stat_i,
  output logic                        wr_en_o,
  output logic [ecb_pkg::ADDR_W-1:0]  wr_addr_o,
  output logic [ecb_pkg::PIX_W-1:0]   wr_data_o,
  output logic                        job_push_o,
  output ecb_pkg::job_t               job_o
);

  logic [ecb_pkg::ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [ecb_pkg::COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic                      in_done_q, in_done_d, done_mid;
  logic                      accept;
  logic [ecb_pkg::WID_W-1:0] in_col_inc, out_col_inc, c_sum, w_m1, c_last;
  logic [ecb_pkg::ROW_W:0]   in_row_inc, out_row_inc, r_sum, h_m1, r_last;
  logic                      win_ready, out_last;

  assign pix_in.ready = fifo_empty_i & ~back_stat_i.busy;
  assign accept       = pix_in.valid & pix_in.ready;
  assign wr_en_o      = accept & (pix_in.func == ecb_pkg::FUNC_PIXEL) & ~in_done_q;
  assign wr_addr_o    = {in_row_q[ecb_pkg::SLOT_W-1:0], in_col_q};
  assign wr_data_o    = {pix_in.in_chan2, pix_in.in_chan1, pix_in.in_chan0};

  always_comb begin
    in_col_inc  = {1'b0, in_col_q} + 1'b1;
    in_row_inc  = {1'b0, in_row_q} + 1'b1;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    done_mid    = in_done_q;
    if (wr_en_o) begin
      if (in_col_inc >= cfg_i.width) begin
        in_col_d = '0;
        if (in_row_inc >= {1'b0, cfg_i.height}) begin
          in_row_d = '0;
          done_mid = 1'b1;
        end else begin
          in_row_d = in_row_inc[ecb_pkg::ROW_W-1:0];
        end
      end else begin
        in_col_d = in_col_inc[ecb_pkg::COL_W-1:0];
      end
    end

    r_sum  = {1'b0, out_row_q} + (ecb_pkg::ROW_W+1)'(cfg_i.radius);
    h_m1   = {1'b0, cfg_i.height} - 1'b1;
    r_last = (r_sum < h_m1) ? r_sum : h_m1;
    c_sum  = {1'b0, out_col_q} + ecb_pkg::WID_W'(cfg_i.radius);
    w_m1   = cfg_i.width - 1'b1;
    c_last = (c_sum < w_m1) ? c_sum : w_m1;

    win_ready = done_mid || ({1'b0, in_row_d} > r_last) ||
                (({1'b0, in_row_d} == r_last) && ({1'b0, in_col_d} > c_last));
    job_push_o = accept & win_ready;

    out_col_inc = {1'b0, out_col_q} + 1'b1;
    out_row_inc = {1'b0, out_row_q} + 1'b1;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last    = 1'b0;
    if (out_col_inc >= cfg_i.width) begin
      out_col_d = '0;
      if (out_row_inc >= {1'b0, cfg_i.height}) begin
        out_row_d = '0;
        out_last  = 1'b1;
      end else begin
        out_row_d = out_row_inc[ecb_pkg::ROW_W-1:0];
      end
    end else begin
      out_col_d = out_col_inc[ecb_pkg::COL_W-1:0];
    end
    in_done_d = (job_push_o && out_last) ? 1'b0 : done_mid;
  end

  assign job_o = '{row: out_row_q, col: out_col_q, last: out_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      in_done_q <= 1'b0;
    end else if (accept) begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      in_done_q <= in_done_d;
      if (job_push_o) begin
        out_row_q <= out_row_d;
        out_col_q <= out_col_d;
      end
    end
  end

endmodule

// ----- rtl/core/ecb_back.sv -----
// Back: walks the window of one position through the line store, sums, divides, outputs.
// Depends on ecb_pkg and ecb_out_if.
module ecb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ecb_pkg::cfg_t               cfg_i,
  input  logic                        fifo_empty_i,
  input  ecb_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        rd_en_o,
  output logic [ecb_pkg::ADDR_W-1:0]  rd_addr_o,
  input  logic [ecb_pkg::PIX_W-1:0]   rd_data_i,
  ecb_out_if.source                   pix_out,
  output ecb_pkg::back_stat_t         stat_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } back_state_e;

  back_state_e                state_q, state_d;
  logic                       rd_vld_q;
  ecb_pkg::job_t              job_q;
  logic [ecb_pkg::STEP_W-1:0] i_q, j_q, two_r, rad4;
  logic                       phase_q;
  logic [ecb_pkg::STEP_W-1:0] i_d, j_d;
  logic                       phase_d, last_step;
  logic [ecb_pkg::SUM_W-1:0]  sum_q [3];
  logic [ecb_pkg::SUM_W-1:0]  quo_n [3];
  logic [ecb_pkg::CNT_W-1:0]  rem_q [3];
  logic [ecb_pkg::CNT_W-1:0]  rem_n [3];
  logic [ecb_pkg::CNT_W:0]    rem_sh [3];
  logic [ecb_pkg::CNT_W-1:0]  cnt_q;
  logic [ecb_pkg::STEP_W-1:0] div_cnt_q;
  logic [ecb_pkg::ROW_W+1:0]  r_pos;
  logic [ecb_pkg::WID_W:0]    c_pos;
  logic                       in_bounds;
  logic [ecb_pkg::CHAN_W-1:0] chan0_q, chan1_q, chan2_q;
  logic                       last_q;

  assign two_r = {cfg_i.radius, 1'b0};
  assign rad4  = ecb_pkg::STEP_W'(cfg_i.radius);

  always_comb begin
    r_pos = {2'b00, job_q.row} + (ecb_pkg::ROW_W+2)'(i_q) - (ecb_pkg::ROW_W+2)'(cfg_i.radius);
    c_pos = {2'b00, job_q.col} + (ecb_pkg::WID_W+1)'(j_q) - (ecb_pkg::WID_W+1)'(cfg_i.radius);
    in_bounds = ~r_pos[ecb_pkg::ROW_W+1] && (r_pos[ecb_pkg::ROW_W:0] < {1'b0, cfg_i.height}) &&
                ~c_pos[ecb_pkg::WID_W] && (c_pos[ecb_pkg::WID_W-1:0] < cfg_i.width);

    i_d       = i_q;
    j_d       = j_q;
    phase_d   = phase_q;
    last_step = 1'b0;
    if (cfg_i.shape == ecb_pkg::SHAPE_SQUARE) begin
      last_step = (i_q == two_r) && (j_q == two_r);
      if (j_q == two_r) begin
        j_d = '0;
        i_d = i_q + 1'b1;
      end else begin
        j_d = j_q + 1'b1;
      end
    end else if (!phase_q) begin
      if (i_q == two_r) begin
        phase_d = 1'b1;
        i_d     = rad4;
        j_d     = '0;
      end else begin
        i_d = i_q + 1'b1;
      end
    end else begin
      last_step = (j_q == two_r);
      j_d       = j_q + 1'b1;
    end

    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem_q[k], sum_q[k][ecb_pkg::SUM_W-1]};
      if (rem_sh[k] >= {1'b0, cnt_q}) begin
        rem_n[k] = ecb_pkg::CNT_W'(rem_sh[k] - {1'b0, cnt_q});
        quo_n[k] = {sum_q[k][ecb_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_n[k] = rem_sh[k][ecb_pkg::CNT_W-1:0];
        quo_n[k] = {sum_q[k][ecb_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign rd_en_o   = (state_q == ST_SCAN) && in_bounds;
  assign rd_addr_o = {r_pos[ecb_pkg::SLOT_W-1:0], c_pos[ecb_pkg::COL_W-1:0]};
  assign job_pop_o = (state_q == ST_IDLE) && !fifo_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (!fifo_empty_i) state_d = ST_SCAN;
      ST_SCAN:  if (last_step) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DIV;
      ST_DIV:   if (div_cnt_q == '1) state_d = ST_OUT;
      ST_OUT:   if (pix_out.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + ecb_pkg::SUM_W'(rd_data_i[k*ecb_pkg::CHAN_W +: ecb_pkg::CHAN_W]);
      end
      cnt_q <= cnt_q + 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        job_q   <= job_i;
        i_q     <= '0;
        j_q     <= (cfg_i.shape == ecb_pkg::SHAPE_CROSS) ? rad4 : '0;
        phase_q <= 1'b0;
        cnt_q   <= '0;
        for (int k = 0; k < 3; k++) begin
          sum_q[k] <= '0;
        end
      end
      ST_SCAN: begin
        i_q     <= i_d;
        j_q     <= j_d;
        phase_q <= phase_d;
      end
      ST_DRAIN: begin
        div_cnt_q <= '0;
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= '0;
        end
      end
      ST_DIV: begin
        div_cnt_q <= div_cnt_q + 1'b1;
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= rem_n[k];
          sum_q[k] <= quo_n[k];
        end
        chan0_q <= (cnt_q == '0) ? '0 : quo_n[0][ecb_pkg::CHAN_W-1:0];
        chan1_q <= (cnt_q == '0 || !cfg_i.color) ? '0 : quo_n[1][ecb_pkg::CHAN_W-1:0];
        chan2_q <= (cnt_q == '0 || !cfg_i.color) ? '0 : quo_n[2][ecb_pkg::CHAN_W-1:0];
        last_q  <= job_q.last;
      end
      default: begin
      end
    endcase
  end

  assign pix_out.valid        = (state_q == ST_OUT);
  assign pix_out.out_chan0    = chan0_q;
  assign pix_out.out_chan1    = chan1_q;
  assign pix_out.out_chan2    = chan2_q;
  assign pix_out.window_count = cnt_q;
  assign pix_out.frame_last   = last_q;

  assign stat_o.busy     = (state_q == ST_SCAN) || (state_q == ST_DRAIN) || (state_q == ST_DIV);
  assign stat_o.scanning = (state_q == ST_SCAN) || rd_vld_q;

endmodule

// ----- rtl/core/edge_clipped_box_cross_blur.sv -----
// Top level of the clipped-border box/cross blur: registers, line store, front, queue, back.
// Depends on ecb_pkg, the channel interfaces, ecb_ram, ecb_job_fifo, ecb_front, ecb_back.
//
//   channel   dir   handshake       payload
//   pix_in    in    valid / ready   func, in_chan0..2
//   pix_out   out   valid / ready   out_chan0..2, window_count, frame_last
//   cfg       in    valid / ready   index, data (always ready)
//
// An item producing a result steps through (2r+1)^2 window positions for a square window,
// 2(2r+1) for a cross, then drains, divides and hands off; the single line store read port sets the scan.
// A finished result waits in the output register while the front takes the next item.
// Reset clears counters and the queue; the line store keeps its contents and needs no
// clearing pass.
module edge_clipped_box_cross_blur (
  input logic        clk_i,
  input logic        rst_ni,
  ecb_in_if.sink     pix_in,
  ecb_out_if.source  pix_out,
  ecb_cfg_if.sink    cfg
);

  logic [ecb_pkg::WID_W-1:0]  width_q;
  logic [ecb_pkg::ROW_W-1:0]  height_q;
  logic [ecb_pkg::RAD_W-1:0]  radius_q;
  logic                       shape_q, color_q;
  ecb_pkg::cfg_t              cfg_eff;
  logic                       wr_en, rd_en, job_push, job_pop, fifo_empty, fifo_full;
  logic [ecb_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [ecb_pkg::PIX_W-1:0]  wr_data, rd_data;
  ecb_pkg::job_t              job_in, job_out;
  ecb_pkg::back_stat_t        back_stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ecb_pkg::WID_W'(640);
      height_q <= ecb_pkg::ROW_W'(480);
      radius_q <= ecb_pkg::RAD_W'(1);
      shape_q  <= ecb_pkg::SHAPE_SQUARE;
      color_q  <= 1'b1;
    end else if (cfg.valid) begin
      case (ecb_pkg::cfg_idx_e'(cfg.index))
        ecb_pkg::CFG_FRAME_WIDTH:   width_q  <= cfg.data[ecb_pkg::WID_W-1:0];
        ecb_pkg::CFG_FRAME_HEIGHT:  height_q <= cfg.data;
        ecb_pkg::CFG_WINDOW_RADIUS: radius_q <= cfg.data[ecb_pkg::RAD_W-1:0];
        ecb_pkg::CFG_WINDOW_SHAPE:  shape_q  <= cfg.data[0];
        ecb_pkg::CFG_COLOR_MODE:    color_q  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      cfg_eff.width = ecb_pkg::WID_W'(1);
    end else if (width_q > ecb_pkg::WID_W'(ecb_pkg::MAX_WIDTH)) begin
      cfg_eff.width = ecb_pkg::WID_W'(ecb_pkg::MAX_WIDTH);
    end else begin
      cfg_eff.width = width_q;
    end
    cfg_eff.height = (height_q == '0) ? ecb_pkg::ROW_W'(1) : height_q;
    cfg_eff.radius = ({1'b0, radius_q} > (ecb_pkg::RAD_W+1)'(ecb_pkg::MAX_RADIUS)) ?
                     ecb_pkg::RAD_W'(ecb_pkg::MAX_RADIUS) : radius_q;
    cfg_eff.shape  = shape_q;
    cfg_eff.color  = color_q;
  end

  ecb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_in       (pix_in),
    .cfg_i        (cfg_eff),
    .fifo_empty_i (fifo_empty),
    .back_stat_i  (back_stat),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  ecb_ram #(
    .WIDTH (ecb_pkg::PIX_W),
    .DEPTH (ecb_pkg::RING_ROWS * ecb_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ecb_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  ecb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_eff),
    .fifo_empty_i (fifo_empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .pix_out      (pix_out),
    .stat_o       (back_stat)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !fifo_full) else $error("job pushed into full queue");

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !back_stat.scanning) else $error("line store written during window scan");

  a_pop_starts_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> back_stat.busy) else $error("popped job did not start the back");
`endif

endmodule
